// ===== src/assert_macros.svh =====
// Assertion macros shared by the step-size controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/pssc_pkg.sv =====
// Shared types and constants of the step-size controller.
package pssc_pkg;

    typedef enum logic [1:0] {
        OP_EST = 2'd0,
        OP_UPD = 2'd1,
        OP_CLR = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK  = 2'd0,
        STS_ORD = 2'd1,
        STS_SAT = 2'd2
    } sts_code_t;

    typedef enum logic [2:0] {
        CFG_K1   = 3'd0,
        CFG_K2   = 3'd1,
        CFG_K3   = 3'd2,
        CFG_BIAS = 3'd3,
        CFG_ORD  = 3'd4,
        CFG_ADJ  = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_BIAS, S_SPLIT, S_E1, S_LSEL, S_NORM, S_LPOS, S_LTAB, S_LMUL,
        S_LACC, S_DIV, S_DWAIT, S_EPOS, S_ETAB, S_EMUL, S_EVAL, S_PROD, S_SHIFT,
        S_DONE
    } state_t;

    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
    localparam int NUM_W = 56;
    localparam int QUO_W = 37;
    localparam int ORD_W = 5;

    typedef struct packed {
        state_t     step;
        logic       accept;
        logic       deliver;
        logic [1:0] opnd;
        logic [2:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic op_est;
        logic ord_bad;
        logic div_done;
    } sts_t;

endpackage

// ===== src/pssc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the exponent scaling.
`include "assert_macros.svh"
module pssc_div
    import pssc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [ORD_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient,
    output logic             done
);

    localparam int CW = $clog2(QUO_W + 1);

    logic [QUO_W-1:0] quo_reg;
    logic [ORD_W-1:0] rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ORD_W:0]   trial;
    logic [ORD_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        ge    = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(QUO_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            rem_reg <= ge ? diff[ORD_W-1:0] : trial[ORD_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `ASSERT_NEXT(a_start_clears_done, clk, rst_n, start, !done_reg && busy_reg)

endmodule

// ===== src/pssc_dp.sv =====
// Datapath of the step-size controller: history, logarithms, exponent and scaling.
`include "assert_macros.svh"
module pssc_dp
    import pssc_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [1:0]  opcode,
    input  logic [31:0] step_size,
    input  logic [31:0] error_estimate,
    input  logic [15:0] gain_k1,
    input  logic [15:0] gain_k2,
    input  logic [15:0] gain_k3,
    input  logic [15:0] error_bias,
    input  logic [3:0]  method_order,
    input  logic [3:0]  order_adjust,
    output sts_t        sts,
    output logic [31:0] res_step,
    output logic [1:0]  res_status
);

    localparam int AW  = $clog2(LOG_TABLE_DEPTH + 1);
    localparam int LPW = 32 + AW;
    localparam int EPW = 30 + AW;

    // Entry i of the log table: log2(1 + i/D) in Q2.30 by repeated squaring.
    function automatic logic [31:0] log_entry(input int unsigned i);
        logic [63:0] x;
        logic [31:0] y;
        if (i == LOG_TABLE_DEPTH)
            return 32'h4000_0000;
        x = 64'h8000_0000 + ((64'(i) << 31) / 64'(LOG_TABLE_DEPTH));
        y = '0;
        for (int k = 1; k <= 30; k++)
        begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000)
            begin
                x = x >> 1;
                y[30-k] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry i of the exp table: 2^(i/D) in Q2.30 as a product of square roots.
    function automatic logic [31:0] exp_entry(input int unsigned i);
        logic [63:0] root [1:30];
        logic [63:0] f;
        logic [63:0] v;
        if (i == LOG_TABLE_DEPTH)
            return 32'h8000_0000;
        root[1] = isqrt(64'h2000_0000_0000_0000);
        for (int k = 2; k <= 30; k++)
            root[k] = isqrt(root[k-1] << 30);
        f = (64'(i) << 30) / 64'(LOG_TABLE_DEPTH);
        v = 64'h4000_0000;
        for (int k = 1; k <= 30; k++)
            if (f[30-k])
                v = (v * root[k]) >> 30;
        return v[31:0];
    endfunction

    logic [31:0] log_rom [LOG_TABLE_DEPTH+1];
    logic [31:0] exp_rom [LOG_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= LOG_TABLE_DEPTH; gi++)
    begin : g_rom
        assign log_rom[gi] = log_entry(gi);
        assign exp_rom[gi] = exp_entry(gi);
    end

    op_t                     op_reg;
    logic [31:0]             h_reg;
    logic [31:0]             dsm_reg;
    logic signed [5:0]       ord_reg;
    logic [47:0]             bprod_reg;
    logic [31:0]             last_error_reg;
    logic [31:0]             prior_error_reg;
    logic [31:0]             e1_reg;
    logic [31:0]             x_reg;
    logic [4:0]              m_reg;
    logic [AW-1:0]           idx_reg;
    logic [31:0]             rem_reg;
    logic [31:0]             ta_reg;
    logic [31:0]             diff_reg;
    logic                    up_reg;
    logic [31:0]             ip_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic signed [7:0]       n_reg;
    logic [31:0]             val_reg;
    logic [63:0]             prod_reg;
    logic [31:0]             res_step_reg;
    sts_code_t               res_status_reg;

    logic [31:0]             bsat;
    logic                    ord_bad;
    logic [31:0]             opnd_val;
    logic [15:0]             gain;
    logic [5:0]              nsh;
    logic [LPW-1:0]          lpos;
    logic [31:0]             ta;
    logic [31:0]             tb;
    logic [63:0]             mp;
    logic [31:0]             lint;
    logic signed [36:0]      lval;
    logic signed [53:0]      gp;
    logic [NUM_W-1:0]        mag;
    logic signed [QUO_W:0]   e_val;
    logic [EPW-1:0]          epos;
    logic [QUO_W-1:0]        quo;
    logic                    div_done;
    logic signed [8:0]       s;
    logic [8:0]              ls;
    logic [63:0]             r;
    logic                    sat;

    pssc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.step == S_DIV),
        .dividend (mag[16 +: QUO_W]),
        .divisor  (ord_reg[ORD_W-1:0]),
        .quotient (quo),
        .done     (div_done)
    );

    always_comb
    begin
        bsat    = (bprod_reg[47:44] != 4'd0) ? 32'hFFFF_FFFF : bprod_reg[43:12];
        ord_bad = ord_reg[5] || (ord_reg == 6'sd0);

        case (cmd.opnd)
            2'd0:    opnd_val = e1_reg;
            2'd1:    opnd_val = (last_error_reg == '0) ? 32'd1 : last_error_reg;
            default: opnd_val = (prior_error_reg == '0) ? 32'd1 : prior_error_reg;
        endcase
        case (cmd.opnd)
            2'd0:    gain = gain_k1;
            2'd1:    gain = gain_k2;
            default: gain = gain_k3;
        endcase

        nsh  = 6'd16 >> cmd.cnt;
        lpos = LPW'({x_reg[30:0], 1'b0}) * LPW'(LOG_TABLE_DEPTH);

        if (cmd.step == S_LTAB)
        begin
            ta = log_rom[idx_reg];
            tb = log_rom[idx_reg + 1'b1];
        end
        else
        begin
            ta = exp_rom[idx_reg];
            tb = exp_rom[idx_reg + 1'b1];
        end

        mp   = 64'(diff_reg) * 64'(rem_reg);
        lint = up_reg ? (ta_reg + ip_reg) : (ta_reg - ip_reg);
        lval = ((37'($signed({1'b0, m_reg})) - 37'sd24) <<< 30) + $signed({5'b0, lint});
        gp   = lval * $signed({1'b0, gain});

        mag   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        e_val = num_reg[NUM_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        epos  = EPW'(e_val[29:0]) * EPW'(LOG_TABLE_DEPTH);

        // Final scaling: shift by 30 - n, saturating when the result overflows.
        s   = 9'sd30 - 9'(n_reg);
        ls  = 9'(-s);
        r   = '0;
        sat = 1'b0;
        if (!s[8])
        begin
            if (s < 9'sd64)
                r = prod_reg >> s[5:0];
            sat = (r[63:32] != 32'd0);
        end
        else if (prod_reg != 64'd0)
        begin
            if (ls >= 9'd32)
                sat = 1'b1;
            else if ((prod_reg >> (6'd32 - ls[5:0])) != 64'd0)
                sat = 1'b1;
            else
                r = prod_reg << ls[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg  <= ONE_Q24;
            prior_error_reg <= ONE_Q24;
        end
        else if (cmd.step == S_SPLIT)
        begin
            case (op_reg)
                OP_UPD:
                begin
                    prior_error_reg <= last_error_reg;
                    last_error_reg  <= bsat;
                end
                OP_CLR:
                begin
                    prior_error_reg <= ONE_Q24;
                    last_error_reg  <= ONE_Q24;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= op_t'(opcode);
            h_reg   <= step_size;
            dsm_reg <= error_estimate;
            ord_reg <= $signed({2'b00, method_order}) + 6'($signed(order_adjust));
        end
        case (cmd.step)
            S_BIAS:
                bprod_reg <= 48'(error_bias) * 48'(dsm_reg);
            S_SPLIT:
            begin
                res_step_reg   <= '0;
                res_status_reg <= STS_OK;
                if (op_reg == OP_EST && ord_bad)
                begin
                    res_step_reg   <= h_reg;
                    res_status_reg <= STS_ORD;
                end
            end
            S_E1:
            begin
                e1_reg  <= (bsat == '0) ? 32'd1 : bsat;
                num_reg <= '0;
            end
            S_LSEL:
            begin
                x_reg <= opnd_val;
                m_reg <= 5'd31;
            end
            S_NORM:
            begin
                if ((x_reg >> (6'd32 - nsh)) == 32'd0)
                begin
                    x_reg <= x_reg << nsh;
                    m_reg <= m_reg - nsh[4:0];
                end
            end
            S_LPOS:
            begin
                idx_reg <= lpos[32 +: AW];
                rem_reg <= lpos[31:0];
            end
            S_LTAB, S_ETAB:
            begin
                ta_reg   <= ta;
                up_reg   <= tb >= ta;
                diff_reg <= (tb >= ta) ? (tb - ta) : (ta - tb);
            end
            S_LMUL:
                ip_reg <= mp[63:32];
            S_LACC:
            begin
                if (cmd.opnd == 2'd1)
                    num_reg <= num_reg + NUM_W'(gp);
                else
                    num_reg <= num_reg - NUM_W'(gp);
            end
            S_EPOS:
            begin
                n_reg   <= e_val[QUO_W:30];
                idx_reg <= epos[30 +: AW];
                rem_reg <= {2'b00, epos[29:0]};
            end
            S_EMUL:
                ip_reg <= mp[61:30];
            S_EVAL:
                val_reg <= lint;
            S_PROD:
                prod_reg <= 64'(h_reg) * 64'(val_reg);
            S_SHIFT:
            begin
                res_step_reg   <= sat ? 32'hFFFF_FFFF : r[31:0];
                res_status_reg <= sat ? STS_SAT : STS_OK;
            end
            default: ;
        endcase
    end

    assign sts.op_est   = (op_reg == OP_EST);
    assign sts.ord_bad  = ord_bad;
    assign sts.div_done = div_done;
    assign res_step     = res_step_reg;
    assign res_status   = res_status_reg;

    `ASSERT_NEXT(a_norm_msb, clk, rst_n, (cmd.step == S_NORM) && (cmd.cnt == 3'd4), x_reg[31])

endmodule

// ===== src/pssc_ctrl.sv =====
// Sequencer of the step-size controller.
`include "assert_macros.svh"
module pssc_ctrl
    import pssc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_free,
    input  sts_t sts,
    output cmd_t cmd,
    output logic in_ready
);

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] opnd_reg;
    logic [1:0] opnd_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            opnd_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            opnd_reg  <= opnd_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        opnd_next   = opnd_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.step    = state_reg;
        cmd.opnd    = opnd_reg;
        cmd.cnt     = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_BIAS;
                end
            end
            S_BIAS:  state_next = S_SPLIT;
            S_SPLIT: state_next = (sts.op_est && !sts.ord_bad) ? S_E1 : S_DONE;
            S_E1:
            begin
                opnd_next  = 2'd0;
                state_next = S_LSEL;
            end
            S_LSEL:
            begin
                cnt_next   = 3'd0;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (cnt_reg == 3'd4)
                    state_next = S_LPOS;
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            S_LPOS:  state_next = S_LTAB;
            S_LTAB:  state_next = S_LMUL;
            S_LMUL:  state_next = S_LACC;
            S_LACC:
            begin
                if (opnd_reg == 2'd2)
                    state_next = S_DIV;
                else
                begin
                    opnd_next  = opnd_reg + 2'd1;
                    state_next = S_LSEL;
                end
            end
            S_DIV:   state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (sts.div_done)
                    state_next = S_EPOS;
            end
            S_EPOS:  state_next = S_ETAB;
            S_ETAB:  state_next = S_EMUL;
            S_EMUL:  state_next = S_EVAL;
            S_EVAL:  state_next = S_PROD;
            S_PROD:  state_next = S_SHIFT;
            S_SHIFT: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.deliver = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd.accept, !in_ready)

endmodule

// ===== src/pid_step_size_controller_top.sv =====
// Top level of the PID step-size controller.
// This block proposes a new integrator step size h * e1^(-k1/ord) * e2^(k2/ord) *
// e3^(-k3/ord) from the current biased error and two stored past errors, and it
// keeps that two-entry error history (update shifts in a new biased error, clear
// resets both to 1.0). It takes one item at a time. An update, clear or unused
// opcode passes through the bias and split steps to the done state, which hands
// its result to the output register once that is free. An estimate runs biasing
// and setup, then three base-2 logarithms one after another through a shared unit
// (a five-step normalizing shift, a table lookup with interpolation and a gain
// multiply each), then the one-bit-per-cycle restoring divider by the effective
// order (a start step, thirty-seven shift steps and a wait for its done flag), and
// then the exp2 lookup, final scaling and delivery. When the order is not positive
// the estimate ends after the split step with the step returned unchanged.
// The result sits in an output register, so the next item is accepted while a
// finished result still waits to be taken. Configuration writes are always
// accepted and must only be issued while the block is idle.
`include "assert_macros.svh"
module pid_step_size_controller_top
    import pssc_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] step_size,
    input  logic [31:0] error_estimate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] new_step,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers with their documented reset values.
    logic [15:0] gain_k1_reg;
    logic [15:0] gain_k2_reg;
    logic [15:0] gain_k3_reg;
    logic [15:0] error_bias_reg;
    logic [3:0]  method_order_reg;
    logic [3:0]  order_adjust_reg;

    // Output register: holds one finished item until the consumer takes it.
    logic        out_valid_reg;
    logic [31:0] new_step_reg;
    logic [1:0]  status_reg;

    cmd_t        cmd;
    sts_t        sts;
    logic        out_free;
    logic [31:0] res_step;
    logic [1:0]  res_status;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_k1_reg      <= 16'd38011;
            gain_k2_reg      <= 16'd13763;
            gain_k3_reg      <= 16'd6554;
            error_bias_reg   <= 16'd6144;
            method_order_reg <= 4'd1;
            order_adjust_reg <= 4'hF;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_K1:   gain_k1_reg      <= cfg_data;
                CFG_K2:   gain_k2_reg      <= cfg_data;
                CFG_K3:   gain_k3_reg      <= cfg_data;
                CFG_BIAS: error_bias_reg   <= cfg_data;
                CFG_ORD:  method_order_reg <= cfg_data[3:0];
                CFG_ADJ:  order_adjust_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // The sequencer raises deliver only when the output register is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.deliver)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deliver)
        begin
            new_step_reg <= res_step;
            status_reg   <= res_status;
        end
    end

    pssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    pssc_dp #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .opcode         (opcode),
        .step_size      (step_size),
        .error_estimate (error_estimate),
        .gain_k1        (gain_k1_reg),
        .gain_k2        (gain_k2_reg),
        .gain_k3        (gain_k3_reg),
        .error_bias     (error_bias_reg),
        .method_order   (method_order_reg),
        .order_adjust   (order_adjust_reg),
        .sts            (sts),
        .res_step       (res_step),
        .res_status     (res_status)
    );

    assign out_valid = out_valid_reg;
    assign new_step  = new_step_reg;
    assign status    = status_reg;

    `ASSERT_IMPLY(a_out_from_deliver, clk, rst_n, $rose(out_valid_reg), $past(cmd.deliver))

endmodule

// ===== tb/pid_step_size_controller_top_tb.sv =====
// Self-checking testbench for the PID step-size controller top level.
`timescale 1ns / 100ps

module pid_step_size_controller_top_tb;
    import pssc_pkg::*;

    localparam int TAB_D = 256;
    localparam longint Q30 = 64'sd1073741824;
    localparam longint unsigned M32 = 64'hFFFF_FFFF;

    // One input item as the driver presents it.
    typedef struct {
        op_t         op;
        logic [31:0] h;
        logic [31:0] err;
    } step_req_t;

    // One result item as the block should return it.
    typedef struct {
        logic [31:0] step;
        sts_code_t   sts;
    } step_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [31:0] step_size;
    logic [31:0] error_estimate;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] new_step;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    pid_step_size_controller_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .step_size(step_size), .error_estimate(error_estimate),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_step(new_step), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Queues between the stimulus, the driver, the predictor and the checker.
    step_req_t pending_steps[$];
    step_rsp_t expected_steps[$];
    int        fail_count = 0;
    int        idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    bit        in_taken = 0;

    // The predictor's copy of the configuration and of the error history.
    logic [15:0]       k1_q, k2_q, k3_q, bias_q;
    logic [3:0]        order_q;
    logic signed [3:0] adjust_q;
    logic [31:0]       hist_last, hist_prior;

    longint unsigned log_lut[TAB_D + 1];
    longint unsigned exp_lut[TAB_D + 1];

    always #6 clk = ~clk;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Both tables are built the same way the hardware ROM contents are defined:
    // logs by repeated squaring, exp2 as products of truncated roots of two.
    task automatic build_luts();
        longint unsigned root[31];
        longint unsigned x, f, v;
        logic [31:0] y;
        root[0] = 0;
        root[1] = isqrt(64'd2 << 60);
        for (int k = 2; k <= 30; k++) root[k] = isqrt(root[k - 1] << 30);
        for (int i = 0; i <= TAB_D; i++) begin
            if (i == TAB_D) begin
                log_lut[i] = 64'd1 << 30;
                exp_lut[i] = 64'd1 << 31;
            end
            else begin
                x = (64'd1 << 31) + ((longint'(i) << 31) / TAB_D);
                f = (longint'(i) << 30) / TAB_D;
                v = 64'd1 << 30;
                y = 0;
                for (int k = 1; k <= 30; k++) begin
                    x = (x * x) >> 31;
                    if (x >= (64'd1 << 32)) begin
                        x >>= 1;
                        y[30 - k] = 1'b1;
                    end
                end
                log_lut[i] = y;
                for (int k = 1; k <= 30; k++)
                    if (f[30 - k]) v = (v * root[k]) >> 30;
                exp_lut[i] = v;
            end
        end
    endtask

    function automatic longint unsigned lerp(longint unsigned a, longint unsigned b,
                                             longint unsigned frac, int sh);
        if (b >= a) return a + (((b - a) * frac) >> sh);
        return a - (((a - b) * frac) >> sh);
    endfunction

    function automatic longint log2_q30(logic [31:0] x);
        int m = 31;
        longint unsigned f, pos, idx;
        while (m > 0 && !x[m]) m--;
        f = (longint'(x) << (32 - m)) & M32;
        pos = f * TAB_D;
        idx = pos >> 32;
        return longint'(m - 24) * Q30 + longint'(lerp(log_lut[idx], log_lut[idx + 1],
                                                      pos & M32, 32));
    endfunction

    function automatic logic [31:0] bias_err(logic [31:0] dsm);
        longint unsigned p = (longint'(bias_q) * longint'(dsm)) >> 12;
        return (p > M32) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    // Works out the result of one item and advances the error history.
    function automatic step_rsp_t predict_step(step_req_t rq);
        step_rsp_t rs;
        int ord;
        logic [31:0] e1, e2, e3;
        longint num, ex, n, g, s;
        longint unsigned pos, idx, val, prod, r;
        rs.step = 0;
        rs.sts = STS_OK;
        case (rq.op)
            OP_UPD: begin
                hist_prior = hist_last;
                hist_last = bias_err(rq.err);
                return rs;
            end
            OP_CLR: begin
                hist_last = ONE_Q24;
                hist_prior = ONE_Q24;
                return rs;
            end
            OP_NOP: return rs;
            default: ;
        endcase
        ord = int'(order_q) + int'(adjust_q);
        if (ord <= 0) begin
            rs.step = rq.h;
            rs.sts = STS_ORD;
            return rs;
        end
        e1 = bias_err(rq.err);
        if (e1 == 0) e1 = 1;
        e2 = (hist_last != 0) ? hist_last : 32'd1;
        e3 = (hist_prior != 0) ? hist_prior : 32'd1;
        num = -longint'(k1_q) * log2_q30(e1) + longint'(k2_q) * log2_q30(e2)
              - longint'(k3_q) * log2_q30(e3);
        ex = num / (longint'(ord) * 65536);
        if (ex >= 0) n = ex / Q30;
        else n = -((-ex + (Q30 - 1)) / Q30);
        g = ex - n * Q30;
        pos = longint'(g) * TAB_D;
        idx = pos >> 30;
        val = lerp(exp_lut[idx], exp_lut[idx + 1], pos & (Q30 - 1), 30);
        prod = longint'(rq.h) * val;
        s = 30 - n;
        if (s >= 64) r = 0;
        else if (s >= 0) r = prod >> s;
        else if (prod == 0) r = 0;
        else if (-s >= 32 || prod > (M32 >> (-s))) r = M32 + 1;
        else r = prod << (-s);
        if (r > M32) begin
            rs.step = 32'hFFFF_FFFF;
            rs.sts = STS_SAT;
        end
        else rs.step = r[31:0];
        return rs;
    endfunction

    function automatic bit roll_idle(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Driver: presents pending items at the falling edge and holds each one
    // until the rising edge at which it is accepted.
    always @(negedge clk) begin
        int pct;
        pct = (idle_mode == 1) ? 46 : (idle_mode == 3) ? 34 : 0;
        if (in_valid && !in_taken) begin
            // Keep the current item on the port.
        end
        else if (pending_steps.size() > 0 && !roll_idle(pct)) begin
            step_req_t rq;
            rq = pending_steps.pop_front();
            in_valid <= 1'b1;
            opcode <= rq.op;
            step_size <= rq.h;
            error_estimate <= rq.err;
        end
        else in_valid <= 1'b0;
        pct = (idle_mode == 2) ? 46 : (idle_mode == 3) ? 34 : 0;
        out_ready <= !roll_idle(pct);
    end

    // Monitor: checks delivered results first, then predicts for the item
    // accepted at the same edge.
    always @(posedge clk) begin
        step_rsp_t want;
        step_req_t rq;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_steps.size() == 0) begin
                    $display("%0t: unexpected result new_step=%h status=%0d",
                             $time, new_step, status);
                    fail_count++;
                end
                else begin
                    want = expected_steps.pop_front();
                    if (new_step !== want.step) begin
                        $display("%0t: new_step expected %h actual %h",
                                 $time, want.step, new_step);
                        fail_count++;
                    end
                    if (status !== want.sts) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.sts, status);
                        fail_count++;
                    end
                end
            end
            in_taken = in_valid && in_ready;
            if (in_taken) begin
                rq.op = op_t'(opcode);
                rq.h = step_size;
                rq.err = error_estimate;
                expected_steps.push_back(predict_step(rq));
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_K1:   k1_q = data;
            CFG_K2:   k2_q = data;
            CFG_K3:   k3_q = data;
            CFG_BIAS: bias_q = data;
            CFG_ORD:  order_q = data[3:0];
            CFG_ADJ:  adjust_q = data[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] k1, logic [15:0] k2, logic [15:0] k3,
                             logic [15:0] bias, logic [3:0] ord, logic [3:0] adj);
        write_reg(CFG_K1, k1);
        write_reg(CFG_K2, k2);
        write_reg(CFG_K3, k3);
        write_reg(CFG_BIAS, bias);
        write_reg(CFG_ORD, {12'd0, ord});
        write_reg(CFG_ADJ, {12'd0, adj});
    endtask

    task automatic push_step(op_t op, logic [31:0] h, logic [31:0] err);
        step_req_t rq;
        rq.op = op;
        rq.h = h;
        rq.err = err;
        pending_steps.push_back(rq);
    endtask

    // Waits until every expected result is in, then lets the block settle.
    task automatic drain();
        while (pending_steps.size() > 0 || expected_steps.size() > 0 || in_valid)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Random items: mostly estimates interleaved with history updates so that
    // the stored errors keep changing, plus clears and the unused opcode.
    task automatic push_random(int count);
        int sel;
        op_t op;
        logic [31:0] h, err;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            op = (sel < 50) ? OP_EST : (sel < 80) ? OP_UPD : (sel < 90) ? OP_CLR : OP_NOP;
            h = ($urandom_range(1)) ? $urandom : $urandom_range(32'h0010_0000);
            case ($urandom_range(3))
                0: err = $urandom;
                1: err = $urandom_range(32'h0100_0000) ;
                2: err = $urandom_range(255);
                default: err = 32'h0080_0000 + $urandom_range(32'h0100_0000);
            endcase
            push_step(op, h, err);
        end
    endtask

    initial begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        opcode = OP_NOP;
        step_size = 0;
        error_estimate = 0;
        cfg_valid = 0;
        cfg_index = CFG_K1;
        cfg_data = 0;
        k1_q = 16'd38011;
        k2_q = 16'd13763;
        k3_q = 16'd6554;
        bias_q = 16'd6144;
        order_q = 4'd1;
        adjust_q = -4'sd1;
        hist_last = ONE_Q24;
        hist_prior = ONE_Q24;
        build_luts();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Reset settings give an effective order of zero, so estimates come
        // back unchanged with the order flag.
        push_step(OP_EST, 32'h0001_0000, ONE_Q24);
        push_step(OP_EST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_step(OP_NOP, 32'h1234_5678, 32'h1);
        drain();

        // Directed: field extremes, all opcodes, saturation and the error floor.
        write_all(16'd38011, 16'd13763, 16'd6554, 16'd6144, 4'd4, 4'd0);
        push_step(OP_EST, 32'h0001_0000, ONE_Q24);
        push_step(OP_EST, 32'h0, 32'h0);
        push_step(OP_EST, 32'hFFFF_FFFF, 32'h0);
        push_step(OP_EST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_step(OP_EST, 32'h0000_0001, 32'hFFFF_FFFF);
        push_step(OP_UPD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_step(OP_UPD, 32'h0, 32'h0);
        push_step(OP_EST, 32'h0001_0000, 32'h0000_0100);
        push_step(OP_CLR, 32'h0, 32'h0);
        push_step(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_step(OP_EST, 32'h8000_0000, 32'h0000_0001);
        drain();

        // Largest gains and bias with the smallest positive order, then the
        // largest order with the most negative adjustment.
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd1, 4'd0);
        push_step(OP_UPD, 32'h0, 32'h0000_0010);
        push_step(OP_EST, 32'h0001_0000, 32'h0000_0001);
        push_step(OP_EST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_step(OP_UPD, 32'h0, 32'hFFFF_FFFF);
        push_step(OP_EST, 32'h0001_0000, 32'h0);
        drain();
        write_all(16'd0, 16'd0, 16'd0, 16'd1, 4'd15, 4'b1000);
        push_step(OP_EST, 32'hDEAD_BEEF, 32'h0);
        push_step(OP_UPD, 32'h0, 32'h0);
        push_step(OP_EST, 32'h0001_0000, 32'hFFFF_FFFF);
        drain();

        // Random phases, each with its own settings and idling pattern. The
        // drain between phases also makes the sender wait for every result.
        for (int p = 0; p < 9; p++) begin
            idle_mode = p % 4;
            write_all(pick_gain(), pick_gain(), pick_gain(),
                      ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16384)),
                      4'($urandom_range(1, 15)), 4'($urandom_range(15)));
            push_random(50);
            drain();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
